// ===== src/meog_pkg.sv =====
// Package for the midpoint ellipse outline generator: widths, codes and the microcode table.
`default_nettype none
package meog_pkg;

  localparam int DISPLAY_WIDTH  = 84;
  localparam int DISPLAY_HEIGHT = 48;
  localparam int MAX_RESULTS    = 64;

  localparam int PW = 24;  // decision, gx, gy and product register
  localparam int MW = 14;  // multiplier operand
  localparam int CW = 10;  // unwrapped coordinate
  localparam int AW = 5;   // microcode address
  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_RX2,
    OP_MUL_RY2,
    OP_MUL_RX2Y,
    OP_INIT_GY,
    OP_MUL_RX2RY,
    OP_SUB_T,
    OP_STEP1,
    OP_UPD1,
    OP_MUL_XX,
    OP_MUL_RY2T,
    OP_MUL_YY,
    OP_MUL_RX2T,
    OP_ADD_T,
    OP_MUL_RX2RY2,
    OP_STEP2,
    OP_UPD2,
    OP_EMIT_ERR
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_ZERO,
    C_R1_DONE,
    C_R1_LOOP,
    C_R2_DONE,
    C_R2_LOOP
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [AW-1:0]   target;
  } uword_t;

  localparam logic [AW-1:0] A_IDLE  = 5'd0;
  localparam logic [AW-1:0] A_R1CHK = 5'd8;
  localparam logic [AW-1:0] A_STEP1 = 5'd9;
  localparam logic [AW-1:0] A_R2INI = 5'd11;
  localparam logic [AW-1:0] A_STEP2 = 5'd19;
  localparam logic [AW-1:0] A_ERR   = 5'd22;

  function automatic uword_t ucode(input logic [AW-1:0] addr);
    uword_t w;
    case (addr)
      5'd0:    w = '{OP_LOAD,       C_NO_REQ,  A_IDLE};
      5'd1:    w = '{OP_NOP,        C_ZERO,    A_ERR};
      5'd2:    w = '{OP_MUL_RX2,    C_NEXT,    A_IDLE};
      5'd3:    w = '{OP_MUL_RY2,    C_NEXT,    A_IDLE};
      5'd4:    w = '{OP_MUL_RX2Y,   C_NEXT,    A_IDLE};
      5'd5:    w = '{OP_INIT_GY,    C_NEXT,    A_IDLE};
      5'd6:    w = '{OP_MUL_RX2RY,  C_NEXT,    A_IDLE};
      5'd7:    w = '{OP_SUB_T,      C_NEXT,    A_IDLE};
      5'd8:    w = '{OP_NOP,        C_R1_DONE, A_R2INI};
      5'd9:    w = '{OP_STEP1,      C_NEXT,    A_IDLE};
      5'd10:   w = '{OP_UPD1,       C_R1_LOOP, A_STEP1};
      5'd11:   w = '{OP_MUL_XX,     C_NEXT,    A_IDLE};
      5'd12:   w = '{OP_MUL_RY2T,   C_NEXT,    A_IDLE};
      5'd13:   w = '{OP_MUL_YY,     C_NEXT,    A_IDLE};
      5'd14:   w = '{OP_MUL_RX2T,   C_NEXT,    A_IDLE};
      5'd15:   w = '{OP_ADD_T,      C_NEXT,    A_IDLE};
      5'd16:   w = '{OP_MUL_RX2RY2, C_NEXT,    A_IDLE};
      5'd17:   w = '{OP_SUB_T,      C_NEXT,    A_IDLE};
      5'd18:   w = '{OP_NOP,        C_R2_DONE, A_IDLE};
      5'd19:   w = '{OP_STEP2,      C_NEXT,    A_IDLE};
      5'd20:   w = '{OP_UPD2,       C_R2_LOOP, A_STEP2};
      5'd21:   w = '{OP_NOP,        C_ALWAYS,  A_IDLE};
      5'd22:   w = '{OP_EMIT_ERR,   C_ALWAYS,  A_IDLE};
      default: w = '{OP_NOP,        C_ALWAYS,  A_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic on_screen(input logic signed [CW-1:0] col,
                                     input logic signed [CW-1:0] row);
    return (col >= 0) && (col < CW'(DISPLAY_WIDTH)) &&
           (row >= 0) && (row < CW'(DISPLAY_HEIGHT));
  endfunction

endpackage
`default_nettype wire

// ===== src/midpoint_ellipse_outline_generator_unit.sv =====
// Midpoint ellipse outline generator: microcoded walk over one shared multiplier.
// Each request runs the setup, the region-one walk, the setup for region two and its walk;
// a zero radius answers with a single error result instead. A request yields N points
// (N at most 64); output stalls hold the two-step walk loop over the single multiplier.
// A new request is taken only once the sequencer is back at idle.
// Reset: synchronous, returns the microcode address to idle and clears the result valid.
`default_nettype none
module midpoint_ellipse_outline_generator_unit import meog_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire  [6:0]         centre_x,
  input  wire  [5:0]         centre_y,
  input  wire  [4:0]         radius_x,
  input  wire  [4:0]         radius_y,
  output logic               res_valid,
  input  wire                res_ready,
  output logic signed [7:0]  right_col,
  output logic signed [7:0]  left_col,
  output logic signed [7:0]  lower_row,
  output logic signed [7:0]  upper_row,
  output logic [3:0]         visible_mask,
  output logic               error_flag,
  output logic               last_point
);

  logic [AW-1:0]         pc;
  uword_t                uw;
  logic [6:0]            cx;
  logic [5:0]            cy;
  logic [4:0]            rx;
  logic [4:0]            ry;
  logic [9:0]            rx2;
  logic [9:0]            ry2;
  logic [6:0]            x;
  logic signed [6:0]     y;
  logic signed [PW-1:0]  gx;
  logic signed [PW-1:0]  gy;
  logic signed [PW-1:0]  p;
  logic signed [PW-1:0]  t;
  logic [NW-1:0]         n;
  logic                  flag;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod;
  logic signed [PW-1:0]   step_x;
  logic signed [PW-1:0]   step_y;
  logic signed [PW-1:0]   rx2_w;
  logic signed [PW-1:0]   ry2_w;
  logic signed [6:0]      ym1;
  logic signed [CW-1:0]   rc;
  logic signed [CW-1:0]   lc;
  logic signed [CW-1:0]   lr;
  logic signed [CW-1:0]   ur;
  logic                   emit_op;
  logic                   stall;
  logic                   take;
  logic                   r1_done;
  logic                   r2_done;
  logic                   n_full;
  logic                   p_neg;
  logic                   p_pos;
  logic [AW-1:0]          pc_next;

  assign uw        = ucode(pc);
  assign cmd_ready = (uw.op == OP_LOAD);
  assign emit_op   = (uw.op == OP_STEP1) || (uw.op == OP_STEP2) || (uw.op == OP_EMIT_ERR);
  assign stall     = emit_op && res_valid && !res_ready;

  assign rx2_w  = $signed({{(PW-10){1'b0}}, rx2});
  assign ry2_w  = $signed({{(PW-10){1'b0}}, ry2});
  assign step_x = ry2_w <<< 1;
  assign step_y = rx2_w <<< 1;
  assign ym1    = y - 7'sd1;
  assign n_full = (n == NW'(MAX_RESULTS));
  assign p_neg  = p[PW-1];
  assign p_pos  = !p[PW-1] && (p != '0);
  assign r1_done = !(gx < gy) || n_full;
  assign r2_done = y[6] || n_full;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.op)
      OP_MUL_RX2: begin
        mul_a = $signed({{(MW-5){1'b0}}, rx});
        mul_b = $signed({{(MW-5){1'b0}}, rx});
      end
      OP_MUL_RY2: begin
        mul_a = $signed({{(MW-5){1'b0}}, ry});
        mul_b = $signed({{(MW-5){1'b0}}, ry});
      end
      OP_MUL_RX2Y: begin
        mul_a = $signed({{(MW-10){1'b0}}, rx2});
        mul_b = MW'(y);
      end
      OP_MUL_RX2RY: begin
        mul_a = $signed({{(MW-10){1'b0}}, rx2});
        mul_b = $signed({{(MW-5){1'b0}}, ry});
      end
      OP_MUL_XX: begin
        mul_a = $signed({{(MW-7){1'b0}}, x});
        mul_b = $signed({{(MW-8){1'b0}}, {1'b0, x} + 8'd1});
      end
      OP_MUL_RY2T: begin
        mul_a = $signed({{(MW-10){1'b0}}, ry2});
        mul_b = t[MW-1:0];
      end
      OP_MUL_YY: begin
        mul_a = MW'(ym1);
        mul_b = MW'(ym1);
      end
      OP_MUL_RX2T: begin
        mul_a = $signed({{(MW-10){1'b0}}, rx2});
        mul_b = t[MW-1:0];
      end
      OP_MUL_RX2RY2: begin
        mul_a = $signed({{(MW-10){1'b0}}, rx2});
        mul_b = $signed({{(MW-10){1'b0}}, ry2});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign rc = $signed({{(CW-7){1'b0}}, cx}) + $signed({{(CW-7){1'b0}}, x});
  assign lc = $signed({{(CW-7){1'b0}}, cx}) - $signed({{(CW-7){1'b0}}, x});
  assign lr = $signed({{(CW-6){1'b0}}, cy}) + CW'(y);
  assign ur = $signed({{(CW-6){1'b0}}, cy}) - CW'(y);

  always_comb begin
    case (uw.cond)
      C_NEXT:    take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NO_REQ:  take = !cmd_valid;
      C_ZERO:    take = (rx == '0) || (ry == '0);
      C_R1_DONE: take = r1_done;
      C_R1_LOOP: take = !r1_done;
      C_R2_DONE: take = r2_done;
      C_R2_LOOP: take = !r2_done;
      default:   take = 1'b1;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!stall) begin
      case (uw.op)
        OP_LOAD: begin
          cx <= centre_x;
          cy <= centre_y;
          rx <= radius_x;
          ry <= radius_y;
          x  <= '0;
          y  <= $signed({2'b00, radius_y});
          gx <= '0;
          n  <= '0;
        end
        OP_MUL_RX2:    rx2 <= prod[9:0];
        OP_MUL_RY2:    ry2 <= prod[9:0];
        OP_MUL_RX2Y:   t   <= prod[PW-1:0];
        OP_INIT_GY: begin
          gy <= t <<< 1;
          p  <= ry2_w + (rx2_w >>> 2);
        end
        OP_MUL_RX2RY:  t   <= prod[PW-1:0];
        OP_SUB_T:      p   <= p - t;
        OP_STEP1: begin
          n    <= n + NW'(1);
          x    <= x + 7'd1;
          gx   <= gx + step_x;
          flag <= p_neg;
          if (!p_neg) begin
            y  <= y - 7'sd1;
            gy <= gy - step_y;
          end
        end
        OP_UPD1:       p   <= p + ry2_w + gx - (flag ? '0 : gy);
        OP_MUL_XX:     t   <= prod[PW-1:0];
        OP_MUL_RY2T:   p   <= prod[PW-1:0];
        OP_MUL_YY:     t   <= prod[PW-1:0];
        OP_MUL_RX2T:   t   <= prod[PW-1:0];
        OP_ADD_T:      p   <= p + t;
        OP_MUL_RX2RY2: t   <= prod[PW-1:0];
        OP_STEP2: begin
          n    <= n + NW'(1);
          y    <= y - 7'sd1;
          gy   <= gy - step_y;
          flag <= p_pos;
          if (!p_pos) begin
            x  <= x + 7'd1;
            gx <= gx + step_x;
          end
        end
        OP_UPD2:       p   <= p + rx2_w - gy + (flag ? '0 : gx);
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_op && !stall) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_op && !stall) begin
      if (uw.op == OP_EMIT_ERR) begin
        right_col    <= '0;
        left_col     <= '0;
        lower_row    <= '0;
        upper_row    <= '0;
        visible_mask <= '0;
        error_flag   <= 1'b1;
        last_point   <= 1'b1;
      end else begin
        right_col    <= rc[7:0];
        left_col     <= lc[7:0];
        lower_row    <= lr[7:0];
        upper_row    <= ur[7:0];
        visible_mask <= {on_screen(lc, ur), on_screen(rc, ur),
                         on_screen(lc, lr), on_screen(rc, lr)};
        error_flag   <= 1'b0;
        last_point   <= (n == NW'(MAX_RESULTS - 1)) ||
                        ((uw.op == OP_STEP2) && (y == '0));
      end
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_flag |-> last_point && (visible_mask == '0))
    else $error("error result not marked last or carries points");

  a_n_bound: assert property (@(posedge clk) disable iff (rst)
    (pc != A_IDLE) && (pc != 5'd1) |-> (n <= NW'(MAX_RESULTS)))
    else $error("result count beyond limit");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second request taken while walking");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(pc))
    else $error("sequencer moved while result stalled");

endmodule
`default_nettype wire
